// File: hw/rtl/kmcd_pkg.sv
// Shared types, constants and microcode table for the keypad matrix change detector.
package kmcd_pkg;

	localparam int ROW_COUNT  = 9;
	localparam int GROUND_ROW = 8;
	localparam int CHANGE_BIT = 15;
	localparam int ROW_W      = $clog2(ROW_COUNT);
	localparam int PC_W       = 4;

	typedef enum logic [1:0] {
		ST_CHANGED  = 2'd0,
		ST_NOCHANGE = 2'd1,
		ST_UNSTABLE = 2'd2,
		ST_GLITCH   = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		OP_NOP,
		OP_SCAN,
		OP_UPDATE,
		OP_EMIT_UNSTABLE,
		OP_EMIT_GLITCH,
		OP_EMIT_NOCHANGE
	} op_t;

	typedef enum logic [2:0] {
		CD_ALWAYS,
		CD_NO_BEAT,
		CD_UNSTABLE,
		CD_GLITCH,
		CD_NO_CHANGE,
		CD_MORE_ROWS
	} cond_t;

	typedef struct packed {
		op_t              op;
		cond_t            cond;
		logic [PC_W-1:0]  target;
	} uword_t;

	localparam logic [PC_W-1:0] PC_IDLE     = 4'd0;
	localparam logic [PC_W-1:0] PC_SCAN     = 4'd4;
	localparam logic [PC_W-1:0] PC_UPDATE   = 4'd5;
	localparam logic [PC_W-1:0] PC_UNSTABLE = 4'd6;
	localparam logic [PC_W-1:0] PC_GLITCH   = 4'd7;
	localparam logic [PC_W-1:0] PC_NOCHANGE = 4'd8;

	function automatic uword_t ucode(input logic [PC_W-1:0] pc);
		uword_t w;
		unique case (pc)
			4'd0:    w = '{OP_NOP,           CD_NO_BEAT,   PC_IDLE};
			4'd1:    w = '{OP_NOP,           CD_UNSTABLE,  PC_UNSTABLE};
			4'd2:    w = '{OP_NOP,           CD_GLITCH,    PC_GLITCH};
			4'd3:    w = '{OP_NOP,           CD_NO_CHANGE, PC_NOCHANGE};
			4'd4:    w = '{OP_SCAN,          CD_MORE_ROWS, PC_SCAN};
			4'd5:    w = '{OP_UPDATE,        CD_ALWAYS,    PC_IDLE};
			4'd6:    w = '{OP_EMIT_UNSTABLE, CD_ALWAYS,    PC_IDLE};
			4'd7:    w = '{OP_EMIT_GLITCH,   CD_ALWAYS,    PC_IDLE};
			4'd8:    w = '{OP_EMIT_NOCHANGE, CD_ALWAYS,    PC_UPDATE};
			default: w = '{OP_NOP,           CD_ALWAYS,    PC_IDLE};
		endcase
		return w;
	endfunction

endpackage

// File: hw/rtl/keypad_matrix_change_detector_unit.sv
// Keypad matrix change detector: microcoded sequencer over a snapshot of nine rows.
// A snapshot is taken only at the idle step; in_stall is high until the sequence is back at idle.
// A snapshot with rows changed runs one scan step per row; unstable or glitch snapshots end in an
// emit step after the checks (no-change: emit then update); an output stall holds the sequence.
// Reset clears the stored rows (no keys pressed), the step counter and output valid.
module keypad_matrix_change_detector_unit
	import kmcd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [23:0] array_word0,
	input  logic [23:0] array_word1,
	input  logic [23:0] array_word2,
	input  logic [23:0] array_word3,
	input  logic [15:0] array_word4,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic [3:0]  row_index,
	output logic [7:0]  changed_mask,
	output logic [7:0]  pressed_mask,
	output logic        last
);

	logic [PC_W-1:0]      pc_q;
	logic [ROW_W-1:0]     row_q;
	logic [7:0]           rows_q [ROW_COUNT];
	logic [7:0]           prev_q [ROW_COUNT];
	logic [ROW_COUNT-1:0] pend_q;
	logic                 unstable_q;
	logic                 glitch_q;
	logic                 out_vld_q;

	logic [7:0]           raw   [ROW_COUNT];
	logic [7:0]           msk   [ROW_COUNT];
	logic [ROW_COUNT-1:0] diff;
	logic [7:0]           common;
	logic                 unstable;
	logic                 glitch;
	logic                 beat;
	uword_t               uw;
	logic                 cond_ok;
	logic                 emit;
	logic                 hold;
	logic [ROW_COUNT-1:0] pend_rest;

	assign beat     = in_valid && !in_stall;
	assign in_stall = (pc_q != PC_IDLE);

	// unpack active-low rows, change-bit check, ground row check, masking and change vector
	always_comb begin
		raw[0] = ~array_word0[7:0];
		raw[1] = ~array_word0[23:16];
		raw[2] = ~array_word1[7:0];
		raw[3] = ~array_word1[23:16];
		raw[4] = ~array_word2[7:0];
		raw[5] = ~array_word2[23:16];
		raw[6] = ~array_word3[7:0];
		raw[7] = ~array_word3[23:16];
		raw[8] = ~array_word4[7:0];
		unstable = (array_word1[CHANGE_BIT] != array_word0[CHANGE_BIT])
			|| (array_word2[CHANGE_BIT] != array_word0[CHANGE_BIT])
			|| (array_word3[CHANGE_BIT] != array_word0[CHANGE_BIT])
			|| (array_word4[CHANGE_BIT] != array_word0[CHANGE_BIT]);
		common = 8'hff;
		for (int i = 0; i < GROUND_ROW; i++) begin
			common = common & raw[i];
		end
		glitch = ((raw[GROUND_ROW] & common) != common);
		for (int i = 0; i < ROW_COUNT; i++) begin
			msk[i]  = (i == GROUND_ROW) ? raw[i] : (raw[i] & ~raw[GROUND_ROW]);
			diff[i] = (msk[i] != prev_q[i]);
		end
	end

	assign uw = ucode(pc_q);

	always_comb begin
		unique case (uw.cond)
			CD_ALWAYS:    cond_ok = 1'b1;
			CD_NO_BEAT:   cond_ok = !beat;
			CD_UNSTABLE:  cond_ok = unstable_q;
			CD_GLITCH:    cond_ok = glitch_q;
			CD_NO_CHANGE: cond_ok = (pend_q == '0);
			CD_MORE_ROWS: cond_ok = (row_q != ROW_W'(ROW_COUNT - 1));
			default:      cond_ok = 1'b0;
		endcase
	end

	always_comb begin
		pend_rest        = pend_q;
		pend_rest[row_q] = 1'b0;
		unique case (uw.op)
			OP_SCAN:          emit = pend_q[row_q];
			OP_EMIT_UNSTABLE,
			OP_EMIT_GLITCH,
			OP_EMIT_NOCHANGE: emit = 1'b1;
			default:          emit = 1'b0;
		endcase
		hold = emit && out_vld_q && out_stall;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q      <= PC_IDLE;
			out_vld_q <= 1'b0;
			row_q     <= '0;
			for (int i = 0; i < ROW_COUNT; i++) begin
				prev_q[i] <= '0;
			end
		end else begin
			out_vld_q <= (emit && !hold) || (out_vld_q && out_stall);
			if (!hold) begin
				pc_q <= cond_ok ? uw.target : pc_q + PC_W'(1);
				unique case (uw.op)
					OP_SCAN: begin
						row_q <= cond_ok ? row_q + ROW_W'(1) : '0;
					end
					OP_UPDATE: begin
						for (int i = 0; i < ROW_COUNT; i++) begin
							prev_q[i] <= rows_q[i];
						end
					end
					default: begin
					end
				endcase
			end
			if (beat) begin
				row_q <= '0;
			end
		end
	end

	// snapshot and result payload
	always_ff @(posedge clk) begin
		if (beat) begin
			rows_q     <= msk;
			pend_q     <= diff;
			unstable_q <= unstable;
			glitch_q   <= glitch;
		end
		if (!hold && emit) begin
			unique case (uw.op)
				OP_SCAN: begin
					status       <= ST_CHANGED;
					row_index    <= 4'(row_q);
					changed_mask <= rows_q[row_q] ^ prev_q[row_q];
					pressed_mask <= rows_q[row_q];
					last         <= (pend_rest == '0);
					pend_q       <= pend_rest;
				end
				OP_EMIT_UNSTABLE,
				OP_EMIT_GLITCH,
				OP_EMIT_NOCHANGE: begin
					status       <= (uw.op == OP_EMIT_UNSTABLE) ? ST_UNSTABLE :
						(uw.op == OP_EMIT_GLITCH) ? ST_GLITCH : ST_NOCHANGE;
					row_index    <= '0;
					changed_mask <= '0;
					pressed_mask <= '0;
					last         <= 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	assign out_valid = out_vld_q;

endmodule

// File: verif/tb.sv
// Testbench for keypad_matrix_change_detector_unit: directed table plus random snapshots.
module tb
	import kmcd_pkg::*;
();

	typedef struct packed {
		status_t    st;
		logic [3:0] row;
		logic [7:0] chg;
		logic [7:0] prs;
		logic       lst;
	} scan_res_t;

	typedef struct packed {
		logic [23:0] w0;
		logic [23:0] w1;
		logic [23:0] w2;
		logic [23:0] w3;
		logic [15:0] w4;
		logic        fixed_exp;
		status_t     st;
		logic [3:0]  row;
		logic [7:0]  chg;
		logic [7:0]  prs;
	} stim_row_t;

	localparam int DIRECTED_ROWS = 15;
	localparam int HOLD_CYCLES   = 300;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [23:0] array_word0;
	logic [23:0] array_word1;
	logic [23:0] array_word2;
	logic [23:0] array_word3;
	logic [15:0] array_word4;
	logic        out_valid;
	logic        out_stall;
	logic [1:0]  status;
	logic [3:0]  row_index;
	logic [7:0]  changed_mask;
	logic [7:0]  pressed_mask;
	logic        last;

	scan_res_t   expected_scans [$];
	scan_res_t   got_scan;
	scan_res_t   want_scan;
	logic [7:0]  key_rows [ROW_COUNT];
	logic [7:0]  held_keys [ROW_COUNT];
	stim_row_t   directed [DIRECTED_ROWS];
	int          mismatches;
	int          idle_mode;
	bit          hold_req;

	keypad_matrix_change_detector_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.array_word0  (array_word0),
		.array_word1  (array_word1),
		.array_word2  (array_word2),
		.array_word3  (array_word3),
		.array_word4  (array_word4),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.status       (status),
		.row_index    (row_index),
		.changed_mask (changed_mask),
		.pressed_mask (pressed_mask),
		.last         (last)
	);

	initial clk = 1'b0;
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	initial begin
		#5_000_000;
		$display("** keypad_matrix_change_detector_unit: FAILED **");
		$finish;
	end

	function automatic void predict_scan(input stim_row_t s, input bit keep);
		logic [23:0] wd [5];
		logic [7:0]  cur [ROW_COUNT];
		logic [7:0]  gnd;
		logic [7:0]  common;
		scan_res_t   r;
		int          n;
		int          k;
		wd[0] = s.w0;
		wd[1] = s.w1;
		wd[2] = s.w2;
		wd[3] = s.w3;
		wd[4] = {8'h00, s.w4};
		r = '0;
		r.lst = 1'b1;
		for (int i = 0; i < 5; i++) begin
			if (wd[i][CHANGE_BIT] != wd[0][CHANGE_BIT]) begin
				r.st = ST_UNSTABLE;
				if (keep)
					expected_scans.push_back(r);
				return;
			end
			cur[2*i] = ~wd[i][7:0];
			if (i < 4)
				cur[2*i+1] = ~wd[i][23:16];
		end
		gnd = cur[GROUND_ROW];
		common = 8'hFF;
		for (int i = 0; i < GROUND_ROW; i++)
			common &= cur[i];
		if ((gnd & common) != common) begin
			r.st = ST_GLITCH;
			if (keep)
				expected_scans.push_back(r);
			return;
		end
		for (int i = 0; i < GROUND_ROW; i++)
			cur[i] &= ~gnd;
		n = 0;
		for (int i = 0; i < ROW_COUNT; i++)
			if (cur[i] != key_rows[i])
				n++;
		if (n == 0) begin
			r.st = ST_NOCHANGE;
			if (keep)
				expected_scans.push_back(r);
		end else begin
			k = 0;
			for (int i = 0; i < ROW_COUNT; i++) begin
				if (cur[i] != key_rows[i]) begin
					r.st  = ST_CHANGED;
					r.row = 4'(i);
					r.chg = cur[i] ^ key_rows[i];
					r.prs = cur[i];
					r.lst = (k == n - 1);
					k++;
					if (keep)
						expected_scans.push_back(r);
				end
			end
		end
		for (int i = 0; i < ROW_COUNT; i++)
			key_rows[i] = cur[i];
	endfunction

	// random snapshot built from a slowly changing set of held keys, or from random words
	function automatic stim_row_t make_snap();
		stim_row_t  s;
		logic [7:0] rw [ROW_COUNT];
		logic       chg;
		int         kind;
		int         col;
		kind = $urandom_range(99);
		s = '0;
		if (kind < 65) begin
			repeat ($urandom_range(3, 1))
				held_keys[$urandom_range(ROW_COUNT - 1)][$urandom_range(7)] ^= 1'b1;
			if ($urandom_range(19) == 0)
				held_keys[$urandom_range(ROW_COUNT - 1)] = $urandom_range(1) ? 8'hFF : 8'h00;
		end
		for (int i = 0; i < ROW_COUNT; i++)
			rw[i] = held_keys[i];
		if (kind >= 83 && kind < 92) begin
			col = $urandom_range(7);
			for (int i = 0; i < GROUND_ROW; i++)
				rw[i][col] = 1'b1;
			rw[GROUND_ROW][col] = 1'b0;
		end
		chg = 1'($urandom_range(1));
		s.w0 = {~rw[1], chg, 7'($urandom), ~rw[0]};
		s.w1 = {~rw[3], chg, 7'($urandom), ~rw[2]};
		s.w2 = {~rw[5], chg, 7'($urandom), ~rw[4]};
		s.w3 = {~rw[7], chg, 7'($urandom), ~rw[6]};
		s.w4 = {chg, 7'($urandom), ~rw[8]};
		if (kind >= 75 && kind < 83) begin
			case ($urandom_range(4))
				0: s.w0[CHANGE_BIT] = ~chg;
				1: s.w1[CHANGE_BIT] = ~chg;
				2: s.w2[CHANGE_BIT] = ~chg;
				3: s.w3[CHANGE_BIT] = ~chg;
				default: s.w4[CHANGE_BIT] = ~chg;
			endcase
		end else if (kind >= 92) begin
			s.w0 = 24'($urandom);
			s.w1 = 24'($urandom);
			s.w2 = 24'($urandom);
			s.w3 = 24'($urandom);
			s.w4 = 16'($urandom);
			if ($urandom_range(1)) begin
				s.w1[CHANGE_BIT] = s.w0[CHANGE_BIT];
				s.w2[CHANGE_BIT] = s.w0[CHANGE_BIT];
				s.w3[CHANGE_BIT] = s.w0[CHANGE_BIT];
				s.w4[CHANGE_BIT] = s.w0[CHANGE_BIT];
			end
		end
		return s;
	endfunction

	// called at a falling edge; returns at the falling edge after the beat
	task automatic offer_snapshot(input stim_row_t s);
		scan_res_t r;
		int        gap_pct;
		gap_pct = (idle_mode == 1) ? 60 : (idle_mode == 3) ? 8 : 0;
		while ($urandom_range(99) < gap_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		array_word0 = s.w0;
		array_word1 = s.w1;
		array_word2 = s.w2;
		array_word3 = s.w3;
		array_word4 = s.w4;
		in_valid    = 1'b1;
		do
			@(posedge clk);
		while (in_stall);
		predict_scan(s, !s.fixed_exp);
		if (s.fixed_exp) begin
			r.st  = s.st;
			r.row = s.row;
			r.chg = s.chg;
			r.prs = s.prs;
			r.lst = 1'b1;
			expected_scans.push_back(r);
		end
		@(negedge clk);
	endtask

	initial begin
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req  = 1'b0;
				out_stall = 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
			end
			case (idle_mode)
				2:       out_stall = ($urandom_range(99) < 60);
				3:       out_stall = ($urandom_range(99) < 8);
				default: out_stall = 1'b0;
			endcase
		end
	end

	task automatic note_mismatch(input string what, input scan_res_t want, input scan_res_t got);
		mismatches++;
		if (mismatches <= 10)
			$display({"mismatch (%s): expected st=%0d row=%0d chg=%h prs=%h last=%0d,",
				" got st=%0d row=%0d chg=%h prs=%h last=%0d"},
				what, want.st, want.row, want.chg, want.prs, want.lst,
				got.st, got.row, got.chg, got.prs, got.lst);
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			got_scan = {status, row_index, changed_mask, pressed_mask, last};
			if (expected_scans.size() == 0) begin
				note_mismatch("unexpected beat", '0, got_scan);
			end else begin
				want_scan = expected_scans.pop_front();
				if (got_scan !== want_scan)
					note_mismatch("field", want_scan, got_scan);
			end
		end
	end

	initial begin
		arst_n      = 1'b0;
		in_valid    = 1'b0;
		array_word0 = '0;
		array_word1 = '0;
		array_word2 = '0;
		array_word3 = '0;
		array_word4 = '0;
		mismatches  = 0;
		idle_mode   = 0;
		hold_req    = 1'b0;
		for (int i = 0; i < ROW_COUNT; i++) begin
			key_rows[i]  = 8'h00;
			held_keys[i] = 8'h00;
		end

		//                 w0          w1          w2          w3          w4       fix  status       row  chg    prs
		directed[0]  = {24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 16'hFFFF, 1'b1, ST_NOCHANGE, 4'd0, 8'h00, 8'h00};
		directed[1]  = {24'hFFFFFF, 24'hFFFFFF, 24'hFF7FFF, 24'hFFFFFF, 16'hFFFF, 1'b1, ST_UNSTABLE, 4'd0, 8'h00, 8'h00};
		directed[2]  = {24'h000000, 24'h000000, 24'h000000, 24'h000000, 16'h0000, 1'b1, ST_CHANGED,  4'd8, 8'hFF, 8'hFF};
		directed[3]  = {24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 16'hFFFF, 1'b1, ST_CHANGED,  4'd8, 8'hFF, 8'h00};
		directed[4]  = {24'hFEFFFE, 24'hFEFFFE, 24'hFEFFFE, 24'hFEFFFE, 16'hFFFF, 1'b1, ST_GLITCH,   4'd0, 8'h00, 8'h00};
		directed[5]  = {24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 16'h7FFF, 1'b1, ST_UNSTABLE, 4'd0, 8'h00, 8'h00};
		directed[6]  = {24'hFF7FFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 16'hFFFF, 1'b1, ST_UNSTABLE, 4'd0, 8'h00, 8'h00};
		// one key in each of rows 0-7
		directed[7]  = {24'hFDFFFE, 24'hF7FFFB, 24'hDFFFEF, 24'h7FFFBF, 16'hFFFF, 1'b0, ST_CHANGED,  4'd0, 8'h00, 8'h00};
		// everything pressed, ground row masks rows 0-7
		directed[8]  = {24'h00FF00, 24'h00FF00, 24'h00FF00, 24'h00FF00, 16'hFF00, 1'b0, ST_CHANGED,  4'd0, 8'h00, 8'h00};
		// all nine rows change
		directed[9]  = {24'hF9FFFC, 24'hE7FFF3, 24'h9FFFCF, 24'h7EFF3F, 16'hFFFF, 1'b0, ST_CHANGED,  4'd0, 8'h00, 8'h00};
		// same keys, ignored bits cleared
		directed[10] = {24'hF980FC, 24'hE780F3, 24'h9F80CF, 24'h7E803F, 16'h80FF, 1'b1, ST_NOCHANGE, 4'd0, 8'h00, 8'h00};
		// ground covers only part of the common columns
		directed[11] = {24'h3F7F3F, 24'h3F7F3F, 24'h3F7F3F, 24'h3F7F3F, 16'h7F7F, 1'b1, ST_GLITCH,   4'd0, 8'h00, 8'h00};
		// ground covers the common column exactly
		directed[12] = {24'hF700F6, 24'hF700F7, 24'hF700F7, 24'hF700F7, 16'h00F7, 1'b0, ST_CHANGED,  4'd0, 8'h00, 8'h00};
		directed[13] = {24'hFF00FF, 24'hFF00FF, 24'hFF00FF, 24'hFF00FF, 16'h00FF, 1'b0, ST_CHANGED,  4'd0, 8'h00, 8'h00};
		directed[14] = {24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 16'hFFFF, 1'b1, ST_NOCHANGE, 4'd0, 8'h00, 8'h00};

		repeat (3) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		for (int i = 0; i < DIRECTED_ROWS; i++)
			offer_snapshot(directed[i]);

		// long output hold-off while the sender keeps offering beats
		hold_req = 1'b1;
		for (int p = 0; p < 4; p++) begin
			idle_mode = p;
			repeat (38)
				offer_snapshot(make_snap());
		end

		in_valid  = 1'b0;
		idle_mode = 0;
		while (expected_scans.size() != 0)
			@(posedge clk);
		repeat (30) @(posedge clk);

		if (mismatches == 0 && expected_scans.size() == 0)
			$display("** keypad_matrix_change_detector_unit: PASSED **");
		else
			$display("** keypad_matrix_change_detector_unit: FAILED **");
		$finish;
	end

endmodule

// File: sim.f
hw/rtl/kmcd_pkg.sv
hw/rtl/keypad_matrix_change_detector_unit.sv
verif/tb.sv
